// ===== src/ttua_pkg.sv =====
// ttua_pkg: shared types and constants for the vessel table with aging
// request/response structs, controller states, controller/datapath signals
// no dependencies
package ttua_pkg;

    localparam int ID_W       = 30;
    localparam int TIME_W     = 32;
    localparam int TEXT_W     = 64;
    localparam int SLOT_IDX_W = 5;

    localparam logic [TIME_W-1:0] STALE_RESET = 32'd360000;

    typedef logic [SLOT_IDX_W-1:0] t_slot_idx;

    typedef enum logic {
        ACT_UPSERT   = 1'b0,
        ACT_SNAPSHOT = 1'b1
    } t_action;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] current_time;
        logic [ID_W-1:0]   target_id;
        logic [TIME_W-1:0] seen_time;
        logic [TEXT_W-1:0] name_text;
        logic [TEXT_W-1:0] payload;
    } t_req;

    typedef struct packed {
        t_slot_idx         slot_index;
        logic [ID_W-1:0]   entry_id;
        logic [TIME_W-1:0] entry_seen_time;
        logic [TEXT_W-1:0] entry_name;
        logic [TEXT_W-1:0] entry_payload;
        logic              final_slot;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] seen;
        logic [TEXT_W-1:0] name;
        logic [TEXT_W-1:0] payload;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_SNAP_RD,
        ST_SNAP_EVAL,
        ST_SNAP_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic rd;
        logic wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic eval_last;
    } t_stat;

endpackage

// ===== src/target_table_upsert_age_out.sv =====
// target_table_upsert_age_out: keyed vessel table with aging and oldest replacement
// top level joining ttua_ctrl and ttua_dp; depends on ttua_pkg
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready    i_in_req  (ttua_pkg::t_req)
//   result    out        o_out_valid / i_out_ready  o_out_rsp (ttua_pkg::t_rsp)
//   config    in         i_cfg_we                   i_cfg_wdata (stale limit)
//
// upsert: scan reads one slot of the table memory per cycle, then drain, write
// snapshot: each slot in turn is read from the table memory, aged
//   and held in the output register until taken
// reset clears the per-slot valid bits at once, no clearing pass
// a stalled result holds the sequencer; no new request until the last slot goes
module target_table_upsert_age_out #(
    parameter int TABLE_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ttua_pkg::TIME_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ttua_pkg::t_req                i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ttua_pkg::t_rsp                o_out_rsp
);

    ttua_pkg::t_cmd  cmd;
    ttua_pkg::t_stat stat;

    ttua_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_req.action),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ttua_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_rsp   (o_out_rsp)
    );

`ifndef SYNTHESIS
    a_no_req_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("request taken while a result is pending");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready again straight after a request");

    a_idle_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_rsp.final_slot |=> o_in_ready)
        else $error("not idle after final slot");

    a_gap_between_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_rsp.final_slot |=> !o_out_valid)
        else $error("next slot shown without a read");
`endif

endmodule

// ===== src/ttua_ctrl.sv =====
// ttua_ctrl: sequencer for the slot scan, upsert write and snapshot stream
// depends on ttua_pkg
module ttua_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_action,
    input  logic            i_out_ready,
    input  ttua_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output ttua_pkg::t_cmd  o_cmd
);

    ttua_pkg::t_state r_state;
    ttua_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttua_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ttua_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_in_action == ttua_pkg::ACT_SNAPSHOT) begin
                        n_state = ttua_pkg::ST_SNAP_RD;
                    end else begin
                        n_state = ttua_pkg::ST_SCAN;
                    end
                end
            end
            ttua_pkg::ST_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ttua_pkg::ST_DRAIN;
                end
            end
            ttua_pkg::ST_DRAIN: begin
                n_state = ttua_pkg::ST_WRITE;
            end
            ttua_pkg::ST_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = ttua_pkg::ST_IDLE;
            end
            ttua_pkg::ST_SNAP_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ttua_pkg::ST_SNAP_EVAL;
            end
            ttua_pkg::ST_SNAP_EVAL: begin
                o_cmd.load_out = 1'b1;
                n_state        = ttua_pkg::ST_SNAP_OUT;
            end
            ttua_pkg::ST_SNAP_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.eval_last) begin
                        n_state = ttua_pkg::ST_IDLE;
                    end else begin
                        n_state = ttua_pkg::ST_SNAP_RD;
                    end
                end
            end
            default: begin
                n_state = ttua_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ttua_dp.sv =====
// ttua_dp: slot memory, valid bits, aging check, match/empty/oldest trackers
// depends on ttua_pkg
module ttua_dp #(
    parameter int TABLE_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ttua_pkg::TIME_W-1:0]   i_cfg_wdata,
    input  ttua_pkg::t_req                i_in_req,
    input  ttua_pkg::t_cmd                i_cmd,
    output ttua_pkg::t_stat               o_stat,
    output ttua_pkg::t_rsp                o_out_rsp
);

    localparam int                IDX_W    = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    ttua_pkg::t_entry r_mem [TABLE_SLOTS];
    ttua_pkg::t_entry r_rd_q;

    logic [TABLE_SLOTS-1:0]          r_slot_vld;
    logic [ttua_pkg::TIME_W-1:0]     r_stale;
    ttua_pkg::t_req                  r_req;
    logic [IDX_W-1:0]                r_idx;
    logic [IDX_W-1:0]                r_eval_idx;
    logic                            r_eval_vld;
    logic                            r_have_match;
    logic [IDX_W-1:0]                r_match_idx;
    logic [ttua_pkg::TEXT_W-1:0]     r_match_name;
    logic                            r_have_empty;
    logic [IDX_W-1:0]                r_empty_idx;
    logic [ttua_pkg::TIME_W-1:0]     r_old_seen;
    logic [IDX_W-1:0]                r_old_idx;
    ttua_pkg::t_rsp                  r_out;

    ttua_pkg::t_entry                rd_ent;
    ttua_pkg::t_entry                eff_ent;
    ttua_pkg::t_entry                wr_ent;
    logic [ttua_pkg::TIME_W-1:0]     age;
    logic                            aged;
    logic                            match_hit;
    logic                            empty_hit;
    logic                            old_hit;
    logic [IDX_W-1:0]                pick;

    always_comb begin
        rd_ent    = r_slot_vld[r_eval_idx] ? r_rd_q : '0;
        age       = r_req.current_time - rd_ent.seen;
        aged      = (rd_ent.id != '0) && (age > r_stale);
        eff_ent   = aged ? '0 : rd_ent;
        match_hit = (r_req.target_id != '0) && (rd_ent.id == r_req.target_id)
                    && !aged && !r_have_match;
        empty_hit = ((rd_ent.id == '0) || aged) && !r_have_empty;
        old_hit   = (r_eval_idx == '0) || (rd_ent.seen < r_old_seen);

        if (r_have_match) begin
            pick = r_match_idx;
        end else if (r_have_empty) begin
            pick = r_empty_idx;
        end else begin
            pick = r_old_idx;
        end

        wr_ent.id      = r_req.target_id;
        wr_ent.seen    = r_req.seen_time;
        wr_ent.payload = r_req.payload;
        // absent name on an update keeps what is stored
        if (r_have_match && (r_req.name_text[7:0] == '0)) begin
            wr_ent.name = r_match_name;
        end else begin
            wr_ent.name = r_req.name_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_q <= r_mem[r_idx];
        end
        if (i_cmd.wr) begin
            r_mem[pick] <= wr_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale      <= ttua_pkg::STALE_RESET;
            r_slot_vld   <= '0;
            r_eval_vld   <= 1'b0;
            r_idx        <= '0;
            r_eval_idx   <= '0;
            r_have_match <= 1'b0;
            r_have_empty <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stale <= i_cfg_wdata;
            end
            r_eval_vld <= i_cmd.rd;
            if (i_cmd.start) begin
                r_idx        <= '0;
                r_have_match <= 1'b0;
                r_have_empty <= 1'b0;
            end
            if (i_cmd.rd) begin
                r_eval_idx <= r_idx;
                r_idx      <= r_idx + IDX_W'(1);
            end
            if (r_eval_vld) begin
                if (aged) begin
                    r_slot_vld[r_eval_idx] <= 1'b0;
                end
                if (match_hit) begin
                    r_have_match <= 1'b1;
                    r_match_idx  <= r_eval_idx;
                    r_match_name <= rd_ent.name;
                end
                if (empty_hit) begin
                    r_have_empty <= 1'b1;
                    r_empty_idx  <= r_eval_idx;
                end
                if (old_hit) begin
                    r_old_seen <= rd_ent.seen;
                    r_old_idx  <= r_eval_idx;
                end
            end
            if (i_cmd.wr) begin
                r_slot_vld[pick] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_in_req;
        end
        if (i_cmd.load_out) begin
            r_out.slot_index      <= ttua_pkg::t_slot_idx'(r_eval_idx);
            r_out.entry_id        <= eff_ent.id;
            r_out.entry_seen_time <= eff_ent.seen;
            r_out.entry_name      <= eff_ent.name;
            r_out.entry_payload   <= eff_ent.payload;
            r_out.final_slot      <= (r_eval_idx == LAST_IDX);
        end
    end

    assign o_stat.idx_last  = (r_idx == LAST_IDX);
    assign o_stat.eval_last = (r_eval_idx == LAST_IDX);
    assign o_out_rsp        = r_out;

endmodule
